### sv/dlarws_pkg.sv
// Shared types, codes and constants of the random walk aggregation block.
package dlarws_pkg;

  // Default grid side and fixed field widths.
  localparam int SIDE_DEF   = 64;
  localparam int COORD_W    = 6;
  localparam int COUNT_W    = 12;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 12'hFFF;
  localparam logic [COUNT_W-1:0] TARGET_RST = 12'd250;

  // Item modes.
  localparam logic [1:0] MODE_SPAWN = 2'd0;
  localparam logic [1:0] MODE_MOVE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Spawn edges.
  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_RIGHT  = 2'd1;
  localparam logic [1:0] EDGE_BOTTOM = 2'd2;
  localparam logic [1:0] EDGE_LEFT   = 2'd3;

  // Move directions.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_WALK = 2'd1;
  localparam logic [1:0] STAT_BUSY    = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         edge_req;
    logic [COORD_W-1:0] offset;
    logic [1:0]         direction;
    logic [COORD_W-1:0] read_row;
    logic [COORD_W-1:0] read_col;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               stuck;
    logic               walker_active;
    logic [COORD_W-1:0] walker_row;
    logic [COORD_W-1:0] walker_col;
    logic               cell_value;
    logic [COUNT_W-1:0] stuck_total;
    logic               done_res;
  } out_word_t;

endpackage

### sv/dlarws_in_if.sv
// Input channel carrying one command word with a valid/ready handshake.
interface dlarws_in_if;
  logic                 valid;
  logic                 ready;
  dlarws_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/dlarws_out_if.sv
// Output channel carrying one result word with a valid/ready handshake.
interface dlarws_out_if;
  logic                  valid;
  logic                  ready;
  dlarws_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/dlarws_cfg_if.sv
// Configuration write channel carrying the crystal target register value.
interface dlarws_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dlarws_pkg::COUNT_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/dla_random_walk_step.sv
// Top level of the diffusion-limited aggregation random walk step engine.
//
// The crystal lives in a RAM with one SIDE-bit row per word, SIDE rows deep, and one
// walker is kept in registers apart from it. A small sequencer drives the single RAM
// read port: a move reads the row above, the walker's row and the row below, then
// decides and optionally writes the walker's row back with its bit set, before the
// result register is loaded. A spawn takes the same steps after an offset step, which
// repeats each time the compare/subtract has to reduce the offset by SIDE (never when
// SIDE is 64 or more). A cell read reads the row and then picks the bit (the RAM is
// skipped when the requested cell lies outside the grid), a misuse (move with no
// walker, spawn while one is active) goes straight to the result register, and a
// clear rewrites the grid one row per cycle. After reset the same clearing pass
// seeds the grid; no word is accepted until it has finished, while the
// configuration port takes writes at any time. The input is ready only while the
// sequencer is idle; a finished result sits in an output register, so the next word
// may be taken while the previous result still waits.
module dla_random_walk_step #(
  parameter int SIDE = dlarws_pkg::SIDE_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dlarws_in_if.sink     in_i,
  dlarws_out_if.source  out_o,
  dlarws_cfg_if.sink    cfg_i
);

  localparam int CW = $clog2(SIDE);
  localparam logic [SIDE-1:0] SEED_BITS = SIDE'(1) << (SIDE / 2);
  localparam logic [CW-1:0]   MAX_POS   = CW'(SIDE - 1);
  localparam logic [CW-1:0]   SEED_ROW  = CW'(SIDE / 2);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_OFF  = 4'd2;
  localparam logic [3:0] ST_UP   = 4'd3;
  localparam logic [3:0] ST_MID  = 4'd4;
  localparam logic [3:0] ST_DN   = 4'd5;
  localparam logic [3:0] ST_END  = 4'd6;
  localparam logic [3:0] ST_RD   = 4'd7;
  localparam logic [3:0] ST_RDD  = 4'd8;
  localparam logic [3:0] ST_LOAD = 4'd9;

  function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] v);
    wrap_inc = (v == MAX_POS) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [CW-1:0] wrap_dec(input logic [CW-1:0] v);
    wrap_dec = (v == '0) ? MAX_POS : v - 1'b1;
  endfunction

  // Widen a 6-bit field to 8 bits and keep the coordinate bits the grid needs.
  function automatic logic [CW-1:0] to_coord(input logic [dlarws_pkg::COORD_W-1:0] v);
    logic [7:0] w;
    w = 8'(v);
    to_coord = w[CW-1:0];
  endfunction

  function automatic logic [dlarws_pkg::COORD_W-1:0] to_field(input logic [CW-1:0] v);
    logic [7:0] w;
    w = 8'(v);
    to_field = w[dlarws_pkg::COORD_W-1:0];
  endfunction

  logic [3:0]                       state_q, state_d;
  logic                             clr_item_q, clr_item_d;
  logic [CW-1:0]                    clr_q, clr_d;
  logic [1:0]                       edge_q, edge_d;
  logic [dlarws_pkg::COORD_W-1:0]   off_q, off_d;
  logic [CW-1:0]                    rr_q, rr_d;
  logic [CW-1:0]                    rc_q, rc_d;
  logic [CW-1:0]                    wy_q, wy_d;
  logic [CW-1:0]                    wx_q, wx_d;
  logic                             live_q, live_d;
  logic [dlarws_pkg::COUNT_W-1:0]   cnt_q, cnt_d;
  logic [dlarws_pkg::COUNT_W-1:0]   target_q;
  logic                             touch_q, touch_d;
  logic [SIDE-1:0]                  row_q, row_d;
  logic [1:0]                       status_q, status_d;
  logic                             stuck_q, stuck_d;
  logic                             cell_q, cell_d;
  logic                             out_valid_q, out_valid_d;
  dlarws_pkg::out_word_t            out_data_q, out_data_d;

  logic                             in_fire;
  logic                             touch_now;
  logic                             mem_we, mem_re;
  logic [CW-1:0]                    mem_waddr, mem_raddr;
  logic [SIDE-1:0]                  mem_wdata, mem_rdata;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // The walker touches crystal if the bit above, either side, or below is set.
  assign touch_now = touch_q | mem_rdata[wx_q];

  // Grid memory port control.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = wy_q;
    mem_we    = 1'b0;
    mem_waddr = wy_q;
    mem_wdata = row_q | (SIDE'(1) << wx_q);
    case (state_q)
      ST_UP: begin
        mem_re    = 1'b1;
        mem_raddr = wrap_dec(wy_q);
      end
      ST_MID: begin
        mem_re    = 1'b1;
        mem_raddr = wy_q;
      end
      ST_DN: begin
        mem_re    = 1'b1;
        mem_raddr = wrap_inc(wy_q);
      end
      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = rr_q;
      end
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = (clr_q == SEED_ROW) ? SEED_BITS : '0;
      end
      ST_END: begin
        mem_we    = touch_now;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_item_d  = clr_item_q;
    clr_d       = clr_q;
    edge_d      = edge_q;
    off_d       = off_q;
    rr_d        = rr_q;
    rc_d        = rc_q;
    wy_d        = wy_q;
    wx_d        = wx_q;
    live_d      = live_q;
    cnt_d       = cnt_q;
    touch_d     = touch_q;
    row_d       = row_q;
    status_d    = status_q;
    stuck_d     = stuck_q;
    cell_d      = cell_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          status_d = dlarws_pkg::STAT_OK;
          stuck_d  = 1'b0;
          cell_d   = 1'b0;
          touch_d  = 1'b0;
          edge_d   = in_i.data.edge_req;
          off_d    = in_i.data.offset;
          rr_d     = to_coord(in_i.data.read_row);
          rc_d     = to_coord(in_i.data.read_col);
          case (in_i.data.mode)
            dlarws_pkg::MODE_SPAWN: begin
              if (live_q) begin
                status_d = dlarws_pkg::STAT_BUSY;
                state_d  = ST_LOAD;
              end else begin
                state_d  = ST_OFF;
              end
            end
            dlarws_pkg::MODE_MOVE: begin
              if (!live_q) begin
                status_d = dlarws_pkg::STAT_NO_WALK;
                state_d  = ST_LOAD;
              end else begin
                case (in_i.data.direction)
                  dlarws_pkg::DIR_UP:    wy_d = wrap_dec(wy_q);
                  dlarws_pkg::DIR_RIGHT: wx_d = wrap_inc(wx_q);
                  dlarws_pkg::DIR_DOWN:  wy_d = wrap_inc(wy_q);
                  default:               wx_d = wrap_dec(wx_q);
                endcase
                state_d = ST_UP;
              end
            end
            dlarws_pkg::MODE_CLEAR: begin
              cnt_d      = '0;
              live_d     = 1'b0;
              wy_d       = '0;
              wx_d       = '0;
              clr_d      = '0;
              clr_item_d = 1'b1;
              state_d    = ST_CLR;
            end
            default: begin
              // Cells outside the grid read as empty.
              if ((9'(in_i.data.read_row) < 9'(SIDE)) &&
                  (9'(in_i.data.read_col) < 9'(SIDE))) begin
                state_d = ST_RD;
              end else begin
                state_d = ST_LOAD;
              end
            end
          endcase
        end
      end
      ST_CLR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == MAX_POS) begin
          state_d = clr_item_q ? ST_LOAD : ST_IDLE;
        end
      end
      ST_OFF: begin
        // The offset is brought into the grid range one subtraction at a time.
        if (9'(off_q) >= 9'(SIDE)) begin
          off_d = off_q - dlarws_pkg::COORD_W'(SIDE);
        end else begin
          case (edge_q)
            dlarws_pkg::EDGE_TOP: begin
              wy_d = '0;
              wx_d = to_coord(off_q);
            end
            dlarws_pkg::EDGE_RIGHT: begin
              wy_d = to_coord(off_q);
              wx_d = MAX_POS;
            end
            dlarws_pkg::EDGE_BOTTOM: begin
              wy_d = MAX_POS;
              wx_d = to_coord(off_q);
            end
            default: begin
              wy_d = to_coord(off_q);
              wx_d = '0;
            end
          endcase
          state_d = ST_UP;
        end
      end
      ST_UP: begin
        state_d = ST_MID;
      end
      ST_MID: begin
        touch_d = mem_rdata[wx_q];
        state_d = ST_DN;
      end
      ST_DN: begin
        row_d   = mem_rdata;
        touch_d = touch_q | mem_rdata[wrap_inc(wx_q)] | mem_rdata[wrap_dec(wx_q)];
        state_d = ST_END;
      end
      ST_END: begin
        stuck_d = touch_now;
        live_d  = !touch_now;
        if (touch_now && (cnt_q != dlarws_pkg::COUNT_MAX)) begin
          cnt_d = cnt_q + 1'b1;
        end
        state_d = ST_LOAD;
      end
      ST_RD: begin
        state_d = ST_RDD;
      end
      ST_RDD: begin
        cell_d  = mem_rdata[rc_q];
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d              = 1'b1;
          out_data_d.status        = status_q;
          out_data_d.stuck         = stuck_q;
          out_data_d.walker_active = live_q;
          out_data_d.walker_row    = to_field(wy_q);
          out_data_d.walker_col    = to_field(wx_q);
          out_data_d.cell_value    = cell_q;
          out_data_d.stuck_total   = cnt_q;
          out_data_d.done_res      = (cnt_q >= target_q);
          state_d                  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_item_q  <= 1'b0;
      clr_q       <= '0;
      wy_q        <= '0;
      wx_q        <= '0;
      live_q      <= 1'b0;
      cnt_q       <= '0;
      target_q    <= dlarws_pkg::TARGET_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_item_q  <= clr_item_d;
      clr_q       <= clr_d;
      wy_q        <= wy_d;
      wx_q        <= wx_d;
      live_q      <= live_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        target_q <= cfg_i.data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    edge_q     <= edge_d;
    off_q      <= off_d;
    rr_q       <= rr_d;
    rc_q       <= rc_d;
    touch_q    <= touch_d;
    row_q      <= row_d;
    status_q   <= status_d;
    stuck_q    <= stuck_d;
    cell_q     <= cell_d;
    out_data_q <= out_data_d;
  end

  dlarws_ram #(
    .WIDTH (SIDE),
    .DEPTH (SIDE)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### sv/dlarws_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dlarws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### tb/sv/dla_random_walk_step_test.sv
// Self-checking testbench of the random walk aggregation step engine.
module dla_random_walk_step_test;
  import dlarws_pkg::*;

  localparam int SIDE = SIDE_DEF;
  localparam logic [COORD_W-1:0] MID = COORD_W'(SIDE / 2);
  localparam int CYCLE_LIMIT = 1_000_000;
  // A clear is the longest item; the wait at the end outlasts two of them.
  localparam int TAIL_CYCLES = 2 * SIDE + 8;

  logic clk;
  logic rst_n;

  dlarws_in_if  in_ch ();
  dlarws_out_if out_ch ();
  dlarws_cfg_if cfg_ch ();

  dla_random_walk_step #(.SIDE(SIDE)) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  // Shadow of the block: the crystal bitmap, the walker and the stick counter,
  // plus the crystal target register as last written.
  logic [SIDE-1:0]    crystal [SIDE];
  logic [COORD_W-1:0] walk_row;
  logic [COORD_W-1:0] walk_col;
  logic               walk_live;
  logic [COUNT_W-1:0] stick_count;
  logic [COUNT_W-1:0] target_reg;

  // Result words still owed by the block, oldest first.
  out_word_t expected_results[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop in case the block hangs or drops a word.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver stalls at random; with recv_idle_pct at zero it never does.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic reseed_crystal();
    for (int r = 0; r < SIDE; r++) begin
      crystal[r] = '0;
    end
    crystal[MID][MID] = 1'b1;
  endtask

  // True when one of the four wrapped neighbours of the cell is crystal.
  // The grid side is a power of two, so plain 6-bit arithmetic wraps.
  function automatic logic next_to_crystal(input logic [COORD_W-1:0] r,
                                           input logic [COORD_W-1:0] c);
    logic [COORD_W-1:0] up;
    logic [COORD_W-1:0] dn;
    logic [COORD_W-1:0] lf;
    logic [COORD_W-1:0] rt;
    up = r - 1'b1;
    dn = r + 1'b1;
    lf = c - 1'b1;
    rt = c + 1'b1;
    return crystal[up][c] | crystal[r][rt] | crystal[dn][c] | crystal[r][lf];
  endfunction

  // After a spawn or a move the walker either freezes into the crystal or
  // keeps walking. A freeze on a cell that is already set still counts.
  task automatic settle_walker(output logic froze);
    if (next_to_crystal(walk_row, walk_col)) begin
      crystal[walk_row][walk_col] = 1'b1;
      if (stick_count != COUNT_MAX) begin
        stick_count++;
      end
      walk_live = 1'b0;
      froze = 1'b1;
    end else begin
      walk_live = 1'b1;
      froze = 1'b0;
    end
  endtask

  // Advances the shadow by one accepted word and queues the result it owes.
  task automatic predict_result(input in_word_t w);
    out_word_t res;
    logic      froze;
    res = '0;
    froze = 1'b0;
    res.status = STAT_OK;
    case (w.mode)
      MODE_SPAWN: begin
        if (walk_live) begin
          res.status = STAT_BUSY;
        end else begin
          case (w.edge_req)
            EDGE_TOP: begin
              walk_row = '0;
              walk_col = w.offset;
            end
            EDGE_RIGHT: begin
              walk_row = w.offset;
              walk_col = COORD_W'(SIDE - 1);
            end
            EDGE_BOTTOM: begin
              walk_row = COORD_W'(SIDE - 1);
              walk_col = w.offset;
            end
            default: begin
              walk_row = w.offset;
              walk_col = '0;
            end
          endcase
          settle_walker(froze);
        end
      end
      MODE_MOVE: begin
        if (!walk_live) begin
          res.status = STAT_NO_WALK;
        end else begin
          case (w.direction)
            DIR_UP:    walk_row = walk_row - 1'b1;
            DIR_RIGHT: walk_col = walk_col + 1'b1;
            DIR_DOWN:  walk_row = walk_row + 1'b1;
            default:   walk_col = walk_col - 1'b1;
          endcase
          settle_walker(froze);
        end
      end
      MODE_CLEAR: begin
        reseed_crystal();
        stick_count = '0;
        walk_live = 1'b0;
        walk_row = '0;
        walk_col = '0;
      end
      default: begin
        res.cell_value = crystal[w.read_row][w.read_col];
      end
    endcase
    res.stuck = froze;
    res.walker_active = walk_live;
    res.walker_row = walk_row;
    res.walker_col = walk_col;
    res.stuck_total = stick_count;
    res.done_res = (stick_count >= target_reg);
    expected_results.push_back(res);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // Every result word taken from the block is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word %h arrived with nothing expected", out_ch.data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, out_ch.data.status);
        check_field("stuck", want.stuck, out_ch.data.stuck);
        check_field("walker_active", want.walker_active, out_ch.data.walker_active);
        check_field("walker_row", want.walker_row, out_ch.data.walker_row);
        check_field("walker_col", want.walker_col, out_ch.data.walker_col);
        check_field("cell_value", want.cell_value, out_ch.data.cell_value);
        check_field("stuck_total", want.stuck_total, out_ch.data.stuck_total);
        check_field("done_res", want.done_res, out_ch.data.done_res);
      end
    end
  end

  // Sends one command word. Valid stays high after acceptance so that back to
  // back words need no second assignment in the same step; it is lowered only
  // when the sender decides to idle or when the caller drains the block.
  task automatic send_word(input in_word_t w);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    predict_result(w);
  endtask

  // Stops sending and waits until every owed result word has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Writes the crystal target. Only called while the block is idle.
  task automatic write_target(input logic [COUNT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    target_reg = value;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // A word with every field random, so that unused fields toggle too.
  function automatic in_word_t random_word();
    logic [31:0]                 rnd;
    logic [$bits(in_word_t)-1:0] raw;
    rnd = $urandom;
    raw = rnd[$bits(in_word_t)-1:0];
    return in_word_t'(raw);
  endfunction

  function automatic in_word_t compose_word(input logic [1:0] mode,
                                            input logic [1:0] edge_sel,
                                            input logic [COORD_W-1:0] offset,
                                            input logic [1:0] direction,
                                            input logic [COORD_W-1:0] rd_row,
                                            input logic [COORD_W-1:0] rd_col);
    in_word_t w;
    w.mode = mode;
    w.edge_req = edge_sel;
    w.offset = offset;
    w.direction = direction;
    w.read_row = rd_row;
    w.read_col = rd_col;
    return w;
  endfunction

  // Step that brings the walker closer to the seed, so that walks end in a
  // stick long before the run is over.
  function automatic logic [1:0] toward_seed();
    logic vert;
    vert = 1'($urandom_range(1));
    if (walk_row == MID) begin
      vert = 1'b0;
    end else if (walk_col == MID) begin
      vert = 1'b1;
    end
    if (vert) begin
      return (walk_row > MID) ? DIR_UP : DIR_DOWN;
    end
    return (walk_col > MID) ? DIR_LEFT : DIR_RIGHT;
  endfunction

  // Grows a horizontal line from the seed out to column zero: each walker is
  // spawned on the left edge of the seed row and marched right until it
  // freezes one cell short of the line. The grid must be freshly seeded.
  task automatic grow_line_to_edge();
    in_word_t w;
    while (!crystal[MID][0]) begin
      w = random_word();
      w.mode = MODE_SPAWN;
      w.edge_req = EDGE_LEFT;
      w.offset = MID;
      send_word(w);
      while (walk_live) begin
        w = random_word();
        w.mode = MODE_MOVE;
        w.direction = DIR_RIGHT;
        send_word(w);
      end
    end
  endtask

  // Directed words at reset target: seed and corner reads, both kinds of
  // misuse, spawns at the far ends of every edge, and one move in each
  // direction across the wrap-around.
  task automatic test_directed_words();
    send_word(compose_word(MODE_READ, EDGE_TOP, 0, DIR_UP, MID, MID));
    send_word(compose_word(MODE_READ, EDGE_LEFT, '1, DIR_LEFT, '1, '1));
    send_word(compose_word(MODE_READ, EDGE_TOP, 0, DIR_UP, 0, 0));
    send_word(compose_word(MODE_MOVE, EDGE_LEFT, '1, DIR_LEFT, '1, '1));
    send_word(compose_word(MODE_CLEAR, EDGE_LEFT, '1, DIR_LEFT, '1, '1));
    send_word(compose_word(MODE_SPAWN, EDGE_TOP, '1, DIR_UP, 0, 0));
    send_word(compose_word(MODE_SPAWN, EDGE_RIGHT, 0, DIR_UP, 0, 0));
    send_word(compose_word(MODE_MOVE, EDGE_TOP, 0, DIR_UP, 0, 0));
    send_word(compose_word(MODE_MOVE, EDGE_TOP, 0, DIR_RIGHT, 0, 0));
    send_word(compose_word(MODE_MOVE, EDGE_TOP, 0, DIR_DOWN, 0, 0));
    send_word(compose_word(MODE_MOVE, EDGE_TOP, 0, DIR_LEFT, 0, 0));
    send_word(compose_word(MODE_CLEAR, EDGE_TOP, 0, DIR_UP, 0, 0));
    send_word(compose_word(MODE_SPAWN, EDGE_RIGHT, 0, DIR_UP, 0, 0));
    send_word(compose_word(MODE_CLEAR, EDGE_TOP, 0, DIR_UP, 0, 0));
    send_word(compose_word(MODE_SPAWN, EDGE_BOTTOM, 0, DIR_UP, 0, 0));
    send_word(compose_word(MODE_CLEAR, EDGE_TOP, 0, DIR_UP, 0, 0));
    send_word(compose_word(MODE_SPAWN, EDGE_LEFT, '1, DIR_UP, 0, 0));
    send_word(compose_word(MODE_SPAWN, EDGE_LEFT, 0, DIR_UP, 0, 0));
    send_word(compose_word(MODE_MOVE, EDGE_LEFT, 0, DIR_RIGHT, '1, 0));
    send_word(compose_word(MODE_CLEAR, EDGE_TOP, 0, DIR_UP, 0, 0));
    send_word(compose_word(MODE_SPAWN, EDGE_BOTTOM, '1, DIR_UP, 0, 0));
  endtask

  // With a target of one, done rises on the first stick. Once the line
  // reaches the left edge, a spawn on the set edge cell freezes again, and a
  // spawn on the right edge freezes through the wrapped neighbour.
  task automatic test_line_growth();
    drain();
    write_target(COUNT_W'(1));
    send_word(compose_word(MODE_CLEAR, EDGE_TOP, 0, DIR_UP, 0, 0));
    grow_line_to_edge();
    send_word(compose_word(MODE_SPAWN, EDGE_LEFT, MID, DIR_UP, 0, 0));
    send_word(compose_word(MODE_SPAWN, EDGE_RIGHT, MID, DIR_UP, 0, 0));
    send_word(compose_word(MODE_READ, EDGE_TOP, 0, DIR_UP, MID, 0));
    send_word(compose_word(MODE_READ, EDGE_TOP, 0, DIR_UP, MID, 1));
    send_word(compose_word(MODE_READ, EDGE_TOP, 0, DIR_UP, MID, '1));
  endtask

  // Mostly well-formed walks: spawn, then moves that drift toward the seed
  // until the walker freezes. Misuse words, reads around the crystal and a
  // rare clear are mixed in.
  task automatic test_random_walks(input int unsigned n_words,
                                   input logic [COUNT_W-1:0] target);
    in_word_t    w;
    int unsigned pick;
    drain();
    write_target(target);
    for (int i = 0; i < n_words; i++) begin
      w = random_word();
      pick = $urandom_range(99);
      if (walk_live) begin
        if (pick < 82) begin
          w.mode = MODE_MOVE;
          if ($urandom_range(9) < 7) begin
            w.direction = toward_seed();
          end
        end else if (pick < 88) begin
          w.mode = MODE_SPAWN;
        end else if (pick < 99) begin
          w.mode = MODE_READ;
        end else begin
          w.mode = MODE_CLEAR;
        end
      end else begin
        if (pick < 65) begin
          w.mode = MODE_SPAWN;
        end else if (pick < 75) begin
          w.mode = MODE_MOVE;
        end else if (pick < 99) begin
          w.mode = MODE_READ;
        end else begin
          w.mode = MODE_CLEAR;
        end
      end
      // Half the reads look around the seed, where the crystal grows.
      if (w.mode == MODE_READ && $urandom_range(1)) begin
        w.read_row = MID - 6'd8 + COORD_W'($urandom_range(16));
        w.read_col = MID - 6'd8 + COORD_W'($urandom_range(16));
      end
      send_word(w);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    send_idle_pct = 34;
    recv_idle_pct = 77;

    reseed_crystal();
    walk_row = '0;
    walk_col = '0;
    walk_live = 1'b0;
    stick_count = '0;
    target_reg = TARGET_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The block seeds its grid after reset; the first word simply waits for
    // ready to rise.
    test_directed_words();
    test_line_growth();
    test_random_walks(365, COUNT_W'($urandom_range(2, 50)));

    send_idle_pct = 77;
    recv_idle_pct = 34;
    test_random_walks(365, COUNT_MAX);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_walks(365, COUNT_W'($urandom_range(1, 30)));

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/dlarws_pkg.sv
sv/dlarws_in_if.sv
sv/dlarws_out_if.sv
sv/dlarws_cfg_if.sv
sv/dlarws_ram.sv
sv/dla_random_walk_step.sv
tb/sv/dla_random_walk_step_test.sv
